FILE: sv/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the two-level exclusive cache model
// Holds the payload structs, the line and row layout kept in both tag RAMs,
// the way-search result and the configuration register indexes.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int ADDR_W     = 48;
  localparam int STAMP_W    = 40;
  // An evicted L1 block rebuilt with wider set bits can grow by up to the
  // L1 set-bit maximum, so L2 tags keep those extra bits.
  localparam int L1_SETS    = 64;
  localparam int L2_SETS    = 256;
  localparam int L1_SB_MAX  = 6;
  localparam int L2_SB_MAX  = 8;
  localparam int TAG_W      = ADDR_W + L1_SB_MAX;
  localparam int WAYS       = 8;
  localparam int WAY_IDX_W  = 3;
  localparam int WAY_CNT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_SET_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_POLICY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SET_BITS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_POLICY   = 3'd6;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic l1_hit;
    logic l2_hit;
    logic mem_read;
    logic mem_write;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 free;
    logic [WAY_IDX_W-1:0] free_way;
  } look_t;

endpackage

FILE: sv/tce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tce_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_lookup: way search over one cache row
// Finds the lowest valid way whose tag matches and the lowest free way,
// looking only at the ways in use.
// ----------------------------------------------------------------------------
module tce_lookup import tce_pkg::*; (
  input  row_t                 row,
  input  logic [TAG_W-1:0]     tag,
  input  logic [WAY_CNT_W-1:0] ways,
  output look_t                look
);

  always_comb begin
    look = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (WAY_CNT_W'(i) < ways) begin
        if (row[i].valid && row[i].tag == tag) begin
          look.hit     = 1'b1;
          look.hit_way = WAY_IDX_W'(i);
        end
        if (!row[i].valid) begin
          look.free     = 1'b1;
          look.free_way = WAY_IDX_W'(i);
        end
      end
    end
  end

endmodule

FILE: sv/two_level_exclusive_cache_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_exclusive_cache_model_core: L1 with exclusive victim L2 model
// Models a set-associative L1 backed by an exclusive L2 with FIFO or LRU
// replacement and reports hit and memory traffic flags for each access.
// ----------------------------------------------------------------------------
//
// Channel   Ports                          Transfer
// input     start, busy, in_data           start high and busy low at a clk edge
// result    out_strobe, out_data           out_strobe high for one cycle
// config    cfg_we, cfg_idx, cfg_wdata     cfg_we high at a clk edge
//
// An L1 hit is answered from the L1 row read alone. An L1 miss that fills a
// free L1 way also reads the L2 row. A miss that replaces an L1 line scans the
// L1 stamps one way per cycle and then reads the L2 set of the evicted block,
// and may scan L2 in the same way.
// The L1 row RAM is read once per pass and the L2 row RAM at most twice.
// After reset a clearing pass zeroes both RAMs; busy is high meanwhile. The
// receiver cannot stall, so each result is shown for exactly one cycle.
module two_level_exclusive_cache_model_core import tce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_strobe,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int L1_AW = $clog2(L1_SETS);
  localparam int L2_AW = $clog2(L2_SETS);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_L1EV  = 9'b000000100,
    S_L2EV  = 9'b000001000,
    S_V1    = 9'b000010000,
    S_L1REP = 9'b000100000,
    S_L2PL  = 9'b001000000,
    S_V2    = 9'b010000000,
    S_L2REP = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [3:0] off_r, l1sb_r, l1w_r, l2sb_r, l2w_r;
  logic       l1pol_r, l2pol_r;
  logic [2:0] l1sb3_r;

  // Access registers.
  logic [L2_AW-1:0]   clr_r, clr_nxt;
  logic [STAMP_W-1:0] acc_r, acc_nxt, ins_r, ins_nxt;
  logic               wr_r, wr_nxt, h2_r, h2_nxt;
  logic [L1_AW-1:0]   set1_r, set1_nxt;
  logic [L2_AW-1:0]   set2_r, set2_nxt, es_r, es_nxt;
  logic [TAG_W-1:0]   tag1_r, tag1_nxt, tag2_r, tag2_nxt, et_r, et_nxt;
  row_t               row1_r, row1_nxt, row2_r, row2_nxt;
  logic [WAY_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WAY_IDX_W-1:0] vic_r, vic_nxt;
  logic               strobe_r, strobe_nxt;
  out_t               res_r, res_nxt;

  // RAM ports.
  logic             we1, re1, we2, re2;
  logic [L1_AW-1:0] waddr1, raddr1;
  logic [L2_AW-1:0] waddr2, raddr2;
  row_t             wrow1, wrow2, rrow1, rrow2;
  logic [ROW_W-1:0] rdata1, rdata2;

  // Clamped configuration.
  logic [2:0]           s1c;
  logic [3:0]           s2c;
  logic [WAY_CNT_W-1:0] w1c, w2c;
  logic [L1_AW-1:0]     msk1;
  logic [L2_AW-1:0]     msk2;

  // Address split of the incoming access.
  logic [ADDR_W-1:0] blk;
  logic [TAG_W-1:0]  ev;
  look_t             lk1, lk2;
  row_t              lk1_row;
  logic [STAMP_W-1:0] acc_sat, ins_sat;
  logic              accept;

  assign s1c  = (l1sb3_r > 3'(L1_SB_MAX)) ? 3'(L1_SB_MAX) : l1sb3_r;
  assign s2c  = (l2sb_r > 4'(L2_SB_MAX)) ? 4'(L2_SB_MAX) : l2sb_r;
  assign w1c  = (l1w_r == '0) ? WAY_CNT_W'(1) :
                (l1w_r > WAY_CNT_W'(WAYS)) ? WAY_CNT_W'(WAYS) : l1w_r;
  assign w2c  = (l2w_r == '0) ? WAY_CNT_W'(1) :
                (l2w_r > WAY_CNT_W'(WAYS)) ? WAY_CNT_W'(WAYS) : l2w_r;
  assign msk1 = L1_AW'((L1_AW + 1)'(1) << s1c) - L1_AW'(1);
  assign msk2 = L2_AW'((L2_AW + 1)'(1) << s2c) - L2_AW'(1);

  assign blk    = in_data.address >> off_r;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign acc_sat = (acc_r == '1) ? acc_r : acc_r + STAMP_W'(1);
  assign ins_sat = (ins_r == '1) ? ins_r : ins_r + STAMP_W'(1);

  // Block address of the L1 victim, rebuilt with the current set bits.
  assign ev = (row1_r[vic_r].tag << s1c) | TAG_W'(set1_r);

  assign rrow1   = row_t'(rdata1);
  assign rrow2   = row_t'(rdata2);
  assign lk1_row = (state_r == S_L1EV) ? rrow1 : row1_r;

  tce_lookup u_look1 (
    .row  (lk1_row),
    .tag  (tag1_r),
    .ways (w1c),
    .look (lk1)
  );

  tce_lookup u_look2 (
    .row  (rrow2),
    .tag  (tag2_r),
    .ways (w2c),
    .look (lk2)
  );

  tce_ram #(.WIDTH(ROW_W), .DEPTH(L1_SETS)) u_l1_ram (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (ROW_W'(wrow1)),
    .re    (re1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  tce_ram #(.WIDTH(ROW_W), .DEPTH(L2_SETS)) u_l2_ram (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr2),
    .wdata (ROW_W'(wrow2)),
    .re    (re2),
    .raddr (raddr2),
    .rdata (rdata2)
  );

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    acc_nxt    = acc_r;
    ins_nxt    = ins_r;
    wr_nxt     = wr_r;
    h2_nxt     = h2_r;
    set1_nxt   = set1_r;
    set2_nxt   = set2_r;
    tag1_nxt   = tag1_r;
    tag2_nxt   = tag2_r;
    es_nxt     = es_r;
    et_nxt     = et_r;
    row1_nxt   = row1_r;
    row2_nxt   = row2_r;
    cnt_nxt    = cnt_r;
    vic_nxt    = vic_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    we1        = 1'b0;
    we2        = 1'b0;
    re1        = 1'b0;
    re2        = 1'b0;
    waddr1     = set1_r;
    waddr2     = set2_r;
    raddr1     = set1_r;
    raddr2     = set2_r;
    wrow1      = row1_r;
    wrow2      = rrow2;

    unique case (state_r)
      S_CLEAR: begin
        we1    = 1'b1;
        we2    = 1'b1;
        waddr1 = clr_r[L1_AW-1:0];
        waddr2 = clr_r;
        wrow1  = '0;
        wrow2  = '0;
        clr_nxt = clr_r + L2_AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          wr_nxt    = in_data.func;
          set1_nxt  = blk[L1_AW-1:0] & msk1;
          set2_nxt  = blk[L2_AW-1:0] & msk2;
          tag1_nxt  = TAG_W'(blk >> s1c);
          tag2_nxt  = TAG_W'(blk >> s2c);
          re1       = 1'b1;
          raddr1    = blk[L1_AW-1:0] & msk1;
          state_nxt = S_L1EV;
        end
      end
      S_L1EV: begin
        row1_nxt = rrow1;
        if (lk1.hit) begin
          // Under LRU the hit line takes the current access count.
          if (l1pol_r == POLICY_LRU) begin
            we1   = 1'b1;
            wrow1 = rrow1;
            wrow1[lk1.hit_way].stamp = acc_r;
          end
          res_nxt    = '{l1_hit: 1'b1, l2_hit: 1'b0, mem_read: 1'b0,
                         mem_write: wr_r};
          strobe_nxt = 1'b1;
          acc_nxt    = acc_sat;
          state_nxt  = S_IDLE;
        end else begin
          re2       = 1'b1;
          raddr2    = set2_r;
          state_nxt = S_L2EV;
        end
      end
      S_L2EV: begin
        h2_nxt = lk2.hit;
        // The block leaves L2 when it moves up.
        if (lk2.hit) begin
          we2   = 1'b1;
          wrow2 = rrow2;
          wrow2[lk2.hit_way].valid = 1'b0;
        end
        if (lk1.free) begin
          we1   = 1'b1;
          wrow1 = row1_r;
          wrow1[lk1.free_way].valid = 1'b1;
          wrow1[lk1.free_way].tag   = tag1_r;
          wrow1[lk1.free_way].stamp = (l1pol_r == POLICY_LRU) ? acc_r : ins_r;
          ins_nxt    = ins_sat;
          res_nxt    = '{l1_hit: 1'b0, l2_hit: lk2.hit, mem_read: !lk2.hit,
                         mem_write: wr_r};
          strobe_nxt = 1'b1;
          acc_nxt    = acc_sat;
          state_nxt  = S_IDLE;
        end else begin
          cnt_nxt   = WAY_CNT_W'(1);
          vic_nxt   = '0;
          state_nxt = S_V1;
        end
      end
      S_V1: begin
        if (cnt_r >= w1c) begin
          state_nxt = S_L1REP;
        end else begin
          if (row1_r[cnt_r[WAY_IDX_W-1:0]].stamp < row1_r[vic_r].stamp) begin
            vic_nxt = cnt_r[WAY_IDX_W-1:0];
          end
          cnt_nxt = cnt_r + WAY_CNT_W'(1);
        end
      end
      S_L1REP: begin
        we1   = 1'b1;
        wrow1 = row1_r;
        wrow1[vic_r].tag   = tag1_r;
        wrow1[vic_r].stamp = (l1pol_r == POLICY_LRU) ? acc_r : ins_r;
        if (l1pol_r == POLICY_FIFO) begin
          ins_nxt = ins_sat;
        end
        es_nxt    = ev[L2_AW-1:0] & msk2;
        et_nxt    = ev >> s2c;
        re2       = 1'b1;
        raddr2    = ev[L2_AW-1:0] & msk2;
        state_nxt = S_L2PL;
      end
      S_L2PL: begin
        row2_nxt = rrow2;
        if (lk2.free) begin
          we2    = 1'b1;
          waddr2 = es_r;
          wrow2  = rrow2;
          wrow2[lk2.free_way].valid = 1'b1;
          wrow2[lk2.free_way].tag   = et_r;
          wrow2[lk2.free_way].stamp = (l2pol_r == POLICY_LRU) ? acc_r : ins_r;
          ins_nxt    = ins_sat;
          res_nxt    = '{l1_hit: 1'b0, l2_hit: h2_r, mem_read: !h2_r,
                         mem_write: wr_r};
          strobe_nxt = 1'b1;
          acc_nxt    = acc_sat;
          state_nxt  = S_IDLE;
        end else begin
          cnt_nxt   = WAY_CNT_W'(1);
          vic_nxt   = '0;
          state_nxt = S_V2;
        end
      end
      S_V2: begin
        if (cnt_r >= w2c) begin
          state_nxt = S_L2REP;
        end else begin
          if (row2_r[cnt_r[WAY_IDX_W-1:0]].stamp < row2_r[vic_r].stamp) begin
            vic_nxt = cnt_r[WAY_IDX_W-1:0];
          end
          cnt_nxt = cnt_r + WAY_CNT_W'(1);
        end
      end
      S_L2REP: begin
        we2    = 1'b1;
        waddr2 = es_r;
        wrow2  = row2_r;
        wrow2[vic_r].tag   = et_r;
        wrow2[vic_r].stamp = (l2pol_r == POLICY_LRU) ? acc_r : ins_r;
        if (l2pol_r == POLICY_FIFO) begin
          ins_nxt = ins_sat;
        end
        res_nxt    = '{l1_hit: 1'b0, l2_hit: h2_r, mem_read: !h2_r,
                       mem_write: wr_r};
        strobe_nxt = 1'b1;
        acc_nxt    = acc_sat;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      acc_r    <= '0;
      ins_r    <= '0;
      strobe_r <= 1'b0;
      off_r    <= 4'd4;
      l1sb3_r  <= 3'd6;
      l1w_r    <= 4'd8;
      l1pol_r  <= POLICY_LRU;
      l2sb_r   <= 4'd8;
      l2w_r    <= 4'd8;
      l2pol_r  <= POLICY_LRU;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      acc_r    <= acc_nxt;
      ins_r    <= ins_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_OFFSET_BITS: off_r   <= cfg_wdata;
          CFG_L1_SET_BITS: l1sb3_r <= cfg_wdata[2:0];
          CFG_L1_WAYS:     l1w_r   <= cfg_wdata;
          CFG_L1_POLICY:   l1pol_r <= cfg_wdata[0];
          CFG_L2_SET_BITS: l2sb_r  <= cfg_wdata;
          CFG_L2_WAYS:     l2w_r   <= cfg_wdata;
          CFG_L2_POLICY:   l2pol_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // The 4-bit L1 set-bit view only widens the 3-bit register for compares.
  assign l1sb_r = {1'b0, l1sb3_r};

  always_ff @(posedge clk) begin
    wr_r   <= wr_nxt;
    h2_r   <= h2_nxt;
    set1_r <= set1_nxt;
    set2_r <= set2_nxt;
    tag1_r <= tag1_nxt;
    tag2_r <= tag2_nxt;
    es_r   <= es_nxt;
    et_r   <= et_nxt;
    row1_r <= row1_nxt;
    row2_r <= row2_nxt;
    cnt_r  <= cnt_nxt;
    vic_r  <= vic_nxt;
    res_r  <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

`ifndef SYNTH
  // A result only follows work on an access.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) != S_IDLE && $past(state_r) != S_CLEAR)
    else $error("result strobe without an access in flight");

  // Exactly one of the three outcome flags is set on each result.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot({out_data.l1_hit, out_data.l2_hit, out_data.mem_read}))
    else $error("outcome flags not exclusive");

  // The access counter never steps back.
  a_acc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> acc_r >= $past(acc_r))
    else $error("access counter went backwards");

  // L2 is never read and written at one row in the same cycle.
  a_l2_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (we2 && re2) |-> waddr2 != raddr2)
    else $error("L2 read and write collide");

  // The configured L1 set bits stay within the register range.
  a_l1sb_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> l1sb_r < 4'd8 && s1c <= 3'(L1_SB_MAX))
    else $error("L1 set bits out of range");
`endif

endmodule
